// ===== src/md5_pkg.sv =====
`timescale 1ns / 1ps

package md5_pkg;

    // Initial chaining words of MD5.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Byte that opens the padding.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Word positions of the bit length in the last block.
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;

    // Round constants, the integer part of abs(sin(i + 1)) * 2^32.
    function automatic logic [31:0] sine_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotation amount per round group and position within the group.
    function automatic logic [4:0] rot_amt(input logic [1:0] grp, input logic [1:0] pos);
        logic [4:0] s;
        case ({grp, pos})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'hA: s = 5'd16;  4'hB: s = 5'd23;
            4'hC: s = 5'd6;   4'hD: s = 5'd10;  4'hE: s = 5'd15;  4'hF: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== src/md5_message_digest.sv =====
`timescale 1ns / 1ps

// MD5 digest engine, one message byte per input word.
// Input channel (i_valid / o_ready): each word may carry a message byte
// (i_byte_present) and may close the message (i_end_of_message). A byte in
// the same word as the end mark is taken first, as the last message byte.
// A word with neither flag changes nothing.
// Output channel (o_valid / i_ready): one word per message, the four chaining
// words A to D; read each little-endian to get the usual 16-byte digest.
// Flow: a byte that does not close a 64-byte block is taken without a stall.
// A byte that fills the block holds o_ready low for the 64 rounds on the
// single shared round unit, one round per cycle, and for the fold of the
// result into the chaining words. The end mark costs a padding step, a
// compression and the hand-over of the digest, plus a second compression
// when the length field spills into a second padding block.
// The digest sits in its own output register, so the next message starts
// while it waits; only a second digest waits for the receiver to drain it.
// Reset loads the MD5 initial chaining words and clears the byte count and
// the block buffer; the engine leaves reset idle and ready for input.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3
);
    import md5_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_ROUND = 6'b000100,
        S_FOLD  = 6'b001000,
        S_LEN   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    // What follows a compression: more message, the length block, or the digest.
    typedef enum logic [1:0] {
        AFT_MSG  = 2'd0,
        AFT_LEN  = 2'd1,
        AFT_DONE = 2'd2
    } t_after;

    t_state      r_state, n_state;
    t_after      r_after, n_after;
    logic        r_fin, n_fin;
    logic [5:0]  r_rnd, n_rnd;
    logic [63:0] r_count, n_count;
    logic [31:0] r_block [16];
    logic [31:0] n_block [16];
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_dig [4];
    logic [31:0] n_dig [4];

    logic [5:0]  byte_pos;
    logic        accept;
    logic        load_rounds;

    // Shared round unit.
    logic [1:0]  grp;
    logic [3:0]  q;
    logic [3:0]  g;
    logic [31:0] mix;
    logic [31:0] t_sum;
    logic [63:0] t_rot;
    logic [31:0] f_new;

    assign accept   = i_valid && o_ready;
    assign byte_pos = r_count[5:0];
    assign grp      = r_rnd[5:4];
    assign q        = r_rnd[3:0];

    always_comb begin
        case (grp)
            2'd0: begin
                g   = q;
                mix = (r_b & r_c) | (~r_b & r_d);
            end
            2'd1: begin
                g   = 4'(q * 4'd5 + 4'd1);
                mix = (r_d & r_b) | (~r_d & r_c);
            end
            2'd2: begin
                g   = 4'(q * 4'd3 + 4'd5);
                mix = r_b ^ r_c ^ r_d;
            end
            default: begin
                g   = 4'(q * 4'd7);
                mix = r_c ^ (r_b | ~r_d);
            end
        endcase
    end

    assign t_sum = r_a + mix + sine_k(r_rnd) + r_block[g];
    assign t_rot = {t_sum, t_sum} << rot_amt(grp, q[1:0]);
    assign f_new = r_b + t_rot[63:32];

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_fin       = r_fin;
        n_rnd       = r_rnd;
        n_count     = r_count;
        n_block     = r_block;
        n_chain     = r_chain;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !i_ready;
        load_rounds = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_fin = i_end_of_message;
                    if (i_byte_present) begin
                        n_block[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] = i_data_byte;
                        n_count = r_count + 64'd1;
                    end
                    if (i_byte_present && byte_pos == 6'd63) begin
                        n_after     = AFT_MSG;
                        load_rounds = 1'b1;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_block[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] = PAD_BYTE;
                // With 56 or more bytes in the block the length goes in a block of its own.
                if (byte_pos[5:3] == 3'b111) begin
                    n_after = AFT_LEN;
                end else begin
                    n_block[LEN_LO_WORD] = {r_count[28:0], 3'b000};
                    n_block[LEN_HI_WORD] = r_count[60:29];
                    n_after = AFT_DONE;
                end
                load_rounds = 1'b1;
            end
            S_ROUND: begin
                n_a   = r_d;
                n_d   = r_c;
                n_c   = r_b;
                n_b   = f_new;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                for (int i = 0; i < 16; i++) begin
                    n_block[i] = '0;
                end
                case (r_after)
                    AFT_MSG:  n_state = r_fin ? S_PAD : S_IDLE;
                    AFT_LEN:  n_state = S_LEN;
                    AFT_DONE: n_state = S_EMIT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_LEN: begin
                n_block[LEN_LO_WORD] = {r_count[28:0], 3'b000};
                n_block[LEN_HI_WORD] = r_count[60:29];
                n_after     = AFT_DONE;
                load_rounds = 1'b1;
            end
            S_EMIT: begin
                // Hand the digest over once the output register is free.
                if (!r_out_valid || i_ready) begin
                    n_dig       = r_chain;
                    n_out_valid = 1'b1;
                    n_chain[0]  = IV_A;
                    n_chain[1]  = IV_B;
                    n_chain[2]  = IV_C;
                    n_chain[3]  = IV_D;
                    n_count     = '0;
                    n_fin       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_rounds) begin
            n_state = S_ROUND;
            n_rnd   = '0;
            n_a     = r_chain[0];
            n_b     = r_chain[1];
            n_c     = r_chain[2];
            n_d     = r_chain[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= AFT_MSG;
            r_fin       <= 1'b0;
            r_rnd       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_chain[0]  <= IV_A;
            r_chain[1]  <= IV_B;
            r_chain[2]  <= IV_C;
            r_chain[3]  <= IV_D;
            for (int i = 0; i < 16; i++) begin
                r_block[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_fin       <= n_fin;
            r_rnd       <= n_rnd;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
            r_block     <= n_block;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_dig <= n_dig;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_digest_word0 = r_dig[0];
    assign o_digest_word1 = r_dig[1];
    assign o_digest_word2 = r_dig[2];
    assign o_digest_word3 = r_dig[3];

    // The last round always hands over to the fold step.
    a_round_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_rnd == 6'd63) |=> (r_state == S_FOLD))
        else $error("round sequence did not end in fold");

    // Padding always starts a compression from round zero.
    a_pad_starts_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |=> (r_state == S_ROUND && r_rnd == 6'd0))
        else $error("padding did not start a compression");

    // Handing over a digest restarts the message state.
    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || i_ready)) |=>
        (r_count == 64'd0 && r_chain[0] == IV_A && r_chain[3] == IV_D && o_valid))
        else $error("digest hand-over did not restart the message");

endmodule

// ===== tb/md5_message_digest_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the streaming MD5 engine. Every accepted input word
// is applied to a behavioral MD5 model kept in this module. When a word closes
// a message, the model's digest goes into a queue. The checker compares each
// digest the block hands over with the oldest queued one, word by word.
module md5_message_digest_tb;

    localparam int CLK_HIGH_NS   = 4;
    localparam int CLK_LOW_NS    = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 700;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_WORDS  = 1040;

    // MD5 round constants, entry 0 first.
    localparam logic [2047:0] SINE_TABLE = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left rotation per round group (rows) and position in the group.
    localparam logic [79:0] SHIFT_TABLE = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [31:0] CHAIN_A0 = 32'h67452301;
    localparam logic [31:0] CHAIN_B0 = 32'hEFCDAB89;
    localparam logic [31:0] CHAIN_C0 = 32'h98BADCFE;
    localparam logic [31:0] CHAIN_D0 = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam int          LEN_LO   = 14;
    localparam int          LEN_HI   = 15;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } digest_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word0;
    logic [31:0] o_digest_word1;
    logic [31:0] o_digest_word2;
    logic [31:0] o_digest_word3;

    md5_message_digest uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_digest_word0   (o_digest_word0),
        .o_digest_word1   (o_digest_word1),
        .o_digest_word2   (o_digest_word2),
        .o_digest_word3   (o_digest_word3)
    );

    always begin
        #CLK_HIGH_NS i_clk = 1'b1;
        #CLK_LOW_NS  i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral MD5 model: chaining words, the block being gathered and
    // the running byte count of the current message.
    // ------------------------------------------------------------------
    logic [31:0] chain_state [4];
    logic [31:0] block_buf [16];
    logic [63:0] msg_byte_count;

    digest_t digests_due [$];
    digest_t due_digest;
    int      mismatch_count = 0;
    int      words_sent = 0;
    int      burst_left = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void clear_message();
        chain_state[0] = CHAIN_A0;
        chain_state[1] = CHAIN_B0;
        chain_state[2] = CHAIN_C0;
        chain_state[3] = CHAIN_D0;
        for (int i = 0; i < 16; i++)
            block_buf[i] = 32'h0;
        msg_byte_count = 64'h0;
    endfunction

    // Runs the 64 rounds on block_buf, folds them into the chain and empties
    // the block for whatever comes next.
    function automatic void compress_block();
        logic [31:0] w [4];
        logic [31:0] mix;
        logic [31:0] sum;
        logic [31:0] rotated;
        int          g;
        int          n;
        for (int i = 0; i < 4; i++)
            w[i] = chain_state[i];
        for (int p = 0; p < 4; p++) begin
            for (int q = 0; q < 16; q++) begin
                case (p)
                    0: begin
                        mix = (w[1] & w[2]) | (~w[1] & w[3]);
                        g = q;
                    end
                    1: begin
                        mix = (w[3] & w[1]) | (~w[3] & w[2]);
                        g = (5 * q + 1) % 16;
                    end
                    2: begin
                        mix = w[1] ^ w[2] ^ w[3];
                        g = (3 * q + 5) % 16;
                    end
                    default: begin
                        mix = w[2] ^ (w[1] | ~w[3]);
                        g = (7 * q) % 16;
                    end
                endcase
                n = 16 * p + q;
                sum = w[0] + mix + SINE_TABLE[32 * (63 - n) +: 32] + block_buf[g];
                rotated = rotl32(sum, SHIFT_TABLE[5 * (15 - (4 * p + q % 4)) +: 5]);
                w[0] = w[3];
                w[3] = w[2];
                w[2] = w[1];
                w[1] = w[1] + rotated;
            end
        end
        for (int i = 0; i < 4; i++)
            chain_state[i] = chain_state[i] + w[i];
        for (int i = 0; i < 16; i++)
            block_buf[i] = 32'h0;
    endfunction

    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
        block_buf[pos[5:2]][8 * pos[1:0] +: 8] = b;
    endfunction

    // Applies one accepted word. Returns 1 with the digest when the word ends
    // the message. A byte in the end word counts as the last message byte.
    function automatic bit absorb_word(input logic [7:0] d, input logic present,
                                       input logic last, output digest_t dg);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        dg = '0;
        if (present) begin
            pos = msg_byte_count[5:0];
            place_byte(pos, d);
            msg_byte_count = msg_byte_count + 64'd1;
            if (pos == 6'd63)
                compress_block();
        end
        if (!last)
            return 1'b0;
        pos = msg_byte_count[5:0];
        bit_len = msg_byte_count << 3;
        place_byte(pos, PAD_MARK);
        // No room left for the length field: it goes into an extra block.
        if (pos >= 6'd56)
            compress_block();
        block_buf[LEN_LO] = bit_len[31:0];
        block_buf[LEN_HI] = bit_len[63:32];
        compress_block();
        dg = '{a: chain_state[0], b: chain_state[1], c: chain_state[2], d: chain_state[3]};
        clear_message();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Words go out in bursts of random length separated by
    // random gaps; valid stays high across a burst.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] d, input logic present, input logic last);
        int      gap;
        digest_t dg;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_data_byte      <= d;
        i_byte_present   <= present;
        i_end_of_message <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (absorb_word(d, present, last, dg))
            digests_due.push_back(dg);
        words_sent++;
    endtask

    // Sends a whole message of random bytes, now and then with a word that
    // carries nothing in between. The end mark rides on the last byte or on
    // a word of its own with an ignored data byte.
    task automatic send_message(input int len, input bit end_on_last);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, end_on_last && (i == len - 1));
        end
        if (!end_on_last || len == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Drops valid and waits until every digest that is due has come out.
    task automatic wait_for_digests();
        i_valid <= 1'b0;
        burst_left = 0;
        while (digests_due.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side. Its ready pattern changes as ready_phase wraps:
    // always ready, mostly ready, a fixed 5-of-8 duty, or a coin
    // flip. A test can also make it hold off entirely for a long stretch.
    // ------------------------------------------------------------------
    event        hold_receiver;
    logic        receiver_held = 1'b0;
    logic [7:0]  ready_phase = 8'h00;
    int          ready_mode = 0;

    initial begin
        forever begin
            @(hold_receiver);
            receiver_held <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            receiver_held <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 8'd1;
        if (ready_phase == 8'hFF)
            ready_mode <= int'($urandom_range(0, 3));
        if (receiver_held) begin
            i_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 3) != 0);
                2:       i_ready <= (ready_phase[2:0] < 3'd5);
                default: i_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: every digest handed over must match the oldest one due.
    // ------------------------------------------------------------------
    function automatic void compare_word(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %08h, got %08h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (digests_due.size() == 0) begin
                $error("digest %08h %08h %08h %08h with no message ended",
                       o_digest_word0, o_digest_word1, o_digest_word2, o_digest_word3);
                mismatch_count++;
            end else begin
                due_digest = digests_due.pop_front();
                compare_word("digest_word0", due_digest.a, o_digest_word0);
                compare_word("digest_word1", due_digest.b, o_digest_word1);
                compare_word("digest_word2", due_digest.c, o_digest_word2);
                compare_word("digest_word3", due_digest.d, o_digest_word3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Words with neither flag, an ignored byte, and empty messages ended
    // both with and without a stray data byte on the end word.
    task automatic test_idle_and_empty();
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
    endtask

    // "abc" ending on the last byte, one-byte messages at both data
    // extremes, ending on the byte and on its own word, then bytes FF 00.
    task automatic test_short_messages();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h3C, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    // Lengths around the padding limit: 55 bytes still fits the length in
    // the same block, 56 and 63 spill into a second one, 64 ends exactly on a
    // block, 120 spills after a full first block.
    task automatic test_block_boundaries();
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        send_message(120, 1'b1);
        wait_for_digests();
    endtask

    // The receiver holds off while short messages keep coming, so the output
    // register and the engine both fill and the input has to stall.
    task automatic test_output_hold_off();
        -> hold_receiver;
        for (int i = 0; i < 6; i++)
            send_message($urandom_range(0, 3), $urandom_range(0, 1));
        wait_for_digests();
    endtask

    // Random messages, mostly short so that plenty of digests come out,
    // with an occasional long one and an occasional full drain in between.
    task automatic test_random_messages();
        int len;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 3) != 0)
                len = $urandom_range(0, 12);
            else
                len = $urandom_range(13, 70);
            send_message(len, $urandom_range(0, 1));
            if ($urandom_range(0, 11) == 0)
                wait_for_digests();
        end
    endtask

    initial begin
        clear_message();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_and_empty();
        test_short_messages();
        test_block_boundaries();
        test_output_hold_off();
        test_random_messages();
        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // A timeout far beyond the slowest correct run.
    initial begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/md5_pkg.sv
src/md5_message_digest.sv
tb/md5_message_digest_tb.sv
